// ===== src/pmnbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pmnbd_pkg
// Types, constants and helpers for the parity-marked nine-bit deframer.
// ----------------------------------------------------------------------------
package pmnbd_pkg;

    localparam logic [7:0] MARK_HEAD = 8'hFF;
    localparam logic [7:0] MARK_TAIL = 8'h00;

    typedef enum logic [1:0] {
        MS_IDLE = 2'd0,
        MS_FF   = 2'd1,
        MS_FF00 = 2'd2
    } t_mark_state;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] letter;
        logic       parity_error;
        logic       ninth_bit;
        logic       run_last;
        logic       frame_end;
    } t_out_item;

    function automatic t_out_item make_item(input logic [7:0] letter,
                                            input logic       err,
                                            input logic       last,
                                            input logic       fend,
                                            input logic       odd_mode);
        t_out_item it;
        it.letter       = letter;
        it.parity_error = err;
        it.ninth_bit    = (odd_mode == (~^letter)) ^ err;
        it.run_last     = last;
        it.frame_end    = fend;
        return it;
    endfunction

endpackage

// ===== src/parity_marked_nine_bit_deframer.sv =====
// ----------------------------------------------------------------------------
// parity_marked_nine_bit_deframer
// Strips 0xFF 0x00 parity-error marks from a received byte stream and
// recovers data byte, error flag and ninth bit for each data byte.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle when not stalled. A byte passes
// an input register and one step of the mark decoder, whose results go into a
// two-entry result buffer. A byte that only extends a mark gives no result, a
// byte that breaks a pending mark gives two (one if it starts a new mark), and the
// output port delivers one result per cycle while not stalled, so the input
// stalls only while the result buffer cannot take what the decoder produces.
// The parity mode register may be written at any time the block is idle.
module parity_marked_nine_bit_deframer
    import pmnbd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic        r_odd_mode;
    logic        r_in_valid;
    t_in_item    r_in;
    t_mark_state r_state;
    t_mark_state n_state;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    t_out_item   r_slot0;
    t_out_item   r_slot1;
    t_out_item   n_slot0;
    t_out_item   n_slot1;

    t_out_item   res0;
    t_out_item   res1;
    logic [1:0]  res_n;
    logic        pop;
    logic        proc;
    logic [1:0]  free;
    logic [1:0]  base_cnt;
    logic        in_acc;

    assign o_cfg_ready = 1'b1;
    assign pop         = (r_cnt != 2'd0) && !i_out_stall;
    assign free        = 2'd2 - r_cnt + {1'b0, pop};
    assign base_cnt    = r_cnt - {1'b0, pop};
    assign proc        = r_in_valid && (res_n <= free);
    assign o_in_stall  = r_in_valid && !proc;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out       = r_slot0;

    always_comb begin
        n_state = r_state;
        res0    = '0;
        res1    = '0;
        res_n   = 2'd0;
        case (r_state)
            MS_FF00: begin
                res0    = make_item(r_in.rx_byte, 1'b1, 1'b1, r_in.buffer_end, r_odd_mode);
                res_n   = 2'd1;
                n_state = MS_IDLE;
            end
            MS_FF: begin
                if (r_in.rx_byte == MARK_TAIL && !r_in.buffer_end) begin
                    n_state = MS_FF00;
                end else if (r_in.rx_byte == MARK_HEAD && !r_in.buffer_end) begin
                    res0    = make_item(MARK_HEAD, 1'b0, 1'b1, 1'b0, r_odd_mode);
                    res_n   = 2'd1;
                    n_state = MS_FF;
                end else begin
                    res0    = make_item(MARK_HEAD, 1'b0, 1'b0, 1'b0, r_odd_mode);
                    res1    = make_item(r_in.rx_byte, 1'b0, 1'b1, r_in.buffer_end,
                                        r_odd_mode);
                    res_n   = 2'd2;
                    n_state = MS_IDLE;
                end
            end
            default: begin
                if (r_in.rx_byte == MARK_HEAD && !r_in.buffer_end) begin
                    n_state = MS_FF;
                end else begin
                    res0    = make_item(r_in.rx_byte, 1'b0, 1'b1, r_in.buffer_end,
                                        r_odd_mode);
                    res_n   = 2'd1;
                    n_state = MS_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        n_slot0 = pop ? r_slot1 : r_slot0;
        n_slot1 = r_slot1;
        n_cnt   = base_cnt;
        if (proc) begin
            n_cnt = base_cnt + res_n;
            case (base_cnt)
                2'd0: begin
                    n_slot0 = res0;
                    n_slot1 = res1;
                end
                2'd1: begin
                    n_slot1 = res0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_odd_mode <= 1'b0;
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_odd_mode <= i_cfg_data;
            end
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
        end
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in.buffer_end |=> r_state == MS_IDLE)
        else $error("state not idle after buffer end");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in.buffer_end |-> res_n != 2'd0)
        else $error("buffer end item gave no result");

    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.frame_end |-> o_out.run_last)
        else $error("frame end on a result that is not the last of its item");

    a_silent_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && res_n == 2'd0 |=> r_state != MS_IDLE)
        else $error("silent item left state idle");

endmodule
